>>> sv/gtp_pkg.sv
package gtp_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_GOAL_X      = 3'd0;
	localparam logic [2:0] CFG_GOAL_Y      = 3'd1;
	localparam logic [2:0] CFG_HEADING_TOL = 3'd2;
	localparam logic [2:0] CFG_ARRIVAL_TOL = 3'd3;
	localparam logic [2:0] CFG_TURN_RATE   = 3'd4;
	localparam logic [2:0] CFG_FWD_RATE    = 3'd5;

	// Drive modes, also the run mode state.
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_TURN  = 2'd1;
	localparam logic [1:0] MODE_DRIVE = 2'd2;

	// Angles inside the block are Q2.30 radians.
	localparam int ZF = 30;
	localparam logic signed [32:0] HALF_PI_Z = 33'sd1686629713;

	// CORDIC operand width, the datapath width after normalization, and the angle width.
	localparam int CIW = 34;
	localparam int CXW = 45;
	localparam int CZW = 33;

	// Arctangent of 2^-i in Q2.30 radians.
	function automatic logic [29:0] atan_at(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0: r = 30'd843314856;
			5'd1: r = 30'd497837829;
			5'd2: r = 30'd263043836;
			5'd3: r = 30'd133525158;
			5'd4: r = 30'd67021686;
			5'd5: r = 30'd33543515;
			5'd6: r = 30'd16775850;
			5'd7: r = 30'd8388437;
			5'd8: r = 30'd4194282;
			5'd9: r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			5'd24: r = 30'd63;
			5'd25: r = 30'd31;
			5'd26: r = 30'd15;
			5'd27: r = 30'd8;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			5'd30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/gtp_cordic.sv
module gtp_cordic import gtp_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [CIW-1:0] y_in,
	input  logic signed [CIW-1:0] x_in,
	output logic                  busy,
	output logic signed [CZW-1:0] z
);

	localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_NORM = 4'b0010,
		C_PRE  = 4'b0100,
		C_ITER = 4'b1000
	} cstate_t;

	cstate_t              state_q;
	logic signed [CXW-1:0] x_q, y_q;
	logic signed [CZW-1:0] z_q;
	logic [CW-1:0]         cnt_q;
	logic [CXW-1:0]        mx, my, m;
	logic signed [CXW-1:0] xs, ys;
	logic signed [CZW-1:0] ang;

	// Magnitudes for the normalization test, the shifted terms and the step angle.
	always_comb begin
		mx = x_q[CXW-1] ? CXW'(-x_q) : x_q;
		my = y_q[CXW-1] ? CXW'(-y_q) : y_q;
		m = mx | my;
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		ang = CZW'({1'b0, atan_at(5'(cnt_q))});
	end

	// Sequencer: normalize, fold into the right half plane, then one step per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_NORM;
					end
				end
				C_NORM: begin
					if (m == '0) begin
						state_q <= C_IDLE;
					end else if (m[CXW-1:40] != '0) begin
						state_q <= C_PRE;
					end
				end
				C_PRE: begin
					cnt_q <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					if (cnt_q == CW'(STEPS - 1)) begin
						state_q <= C_IDLE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Datapath of the shared rotation unit.
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					x_q <= CXW'(x_in);
					y_q <= CXW'(y_in);
					z_q <= '0;
				end
			end
			C_NORM: begin
				if (m[CXW-1:32] == '0) begin
					x_q <= x_q <<< 8;
					y_q <= y_q <<< 8;
				end else if (m[CXW-1:40] == '0) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			C_PRE: begin
				if (x_q[CXW-1]) begin
					if (!y_q[CXW-1]) begin
						x_q <= y_q;
						y_q <= -x_q;
						z_q <= HALF_PI_Z;
					end else begin
						x_q <= -y_q;
						y_q <= x_q;
						z_q <= -HALF_PI_Z;
					end
				end
			end
			default: begin
				if (!y_q[CXW-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + ang;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - ang;
				end
			end
		endcase
	end

	assign busy = (state_q != C_IDLE);
	assign z = z_q;

endmodule

>>> sv/gtp_isqrt.sv
module gtp_isqrt import gtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] radicand,
	output logic        busy,
	output logic [31:0] root
);

	logic [65:0] val_q;
	logic [35:0] rem_q;
	logic [33:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [35:0] rem_n, trial;

	// Two radicand bits per cycle, restoring digit recurrence.
	always_comb begin
		rem_n = {rem_q[33:0], val_q[65:64]};
		trial = {root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 6'd32) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[63:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q <= rem_n - trial;
				root_q <= {root_q[32:0], 1'b1};
			end else begin
				rem_q <= rem_n;
				root_q <= {root_q[32:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = (root_q[33:32] != 2'b00) ? 32'hFFFF_FFFF : root_q[31:0];

endmodule

>>> sv/go_to_point_heading_controller.sv
// Each item takes two passes of the shared CORDIC unit, run one after the other, each preceded
// by up to twelve normalization shifts; the square root runs alongside them. The block is not
// ready while it works, so it takes no new item before the last one has left the sequencer.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous) returns the sequencer to idle, the run mode to idle and
// the configuration registers to their defaults.
module go_to_point_heading_controller import gtp_pkg::*; #(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic               start_req,
	input  logic               cancel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [14:0]        linear_speed,
	output logic signed [15:0] angular_speed,
	output logic [1:0]         drive_mode,
	output logic               finished,
	output logic               succeeded,
	output logic [31:0]        distance_error,
	output logic signed [15:0] heading_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int SH = ZF - ANGLE_FRAC_BITS;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MUL   = 6'b000010,
		S_CORD1 = 6'b000100,
		S_CORD2 = 6'b001000,
		S_DONE  = 6'b010000,
		S_SPARE = 6'b100000
	} state_t;

	state_t state_q;
	logic [3:0] cnt_q;

	// Configuration registers.
	logic signed [31:0] goal_x_q, goal_y_q;
	logic [14:0] head_tol_q, turn_rate_q, fwd_rate_q;
	logic [30:0] arr_tol_q;
	logic [1:0]  run_mode_q;

	// Item registers.
	logic signed [32:0] dx_q, dy_q;
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic start_q, cancel_q;
	logic [31:0] ma_q, mb_q;
	logic signed [32:0] opa, opb;
	logic signed [65:0] prod_q;
	logic [65:0] sq_q;
	logic signed [31:0] qa_q;
	logic [31:0] qb_q;
	logic signed [CZW-1:0] bear_q;

	// Shared unit hookups.
	logic cord_start, cord_busy, sq_start, sq_busy;
	logic signed [CIW-1:0] cord_y, cord_x;
	logic signed [CZW-1:0] cord_z;
	logic [31:0] dist_root;

	// Result arithmetic.
	logic signed [CZW:0] e30;
	logic signed [CZW+1:0] rnd, shf;
	logic signed [15:0] err;
	logic [16:0] err_mag;
	logic load_out;
	logic [1:0]  n_mode;
	logic [14:0] n_lin;
	logic signed [15:0] n_ang;
	logic n_fin, n_succ, running, cancel_eff;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= '0;
			goal_y_q <= '0;
			head_tol_q <= 15'd143;
			arr_tol_q <= 31'd3277;
			turn_rate_q <= 15'd2662;
			fwd_rate_q <= 15'd2458;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GOAL_X:      goal_x_q <= cfg_data;
				CFG_GOAL_Y:      goal_y_q <= cfg_data;
				CFG_HEADING_TOL: head_tol_q <= cfg_data[14:0];
				CFG_ARRIVAL_TOL: arr_tol_q <= cfg_data[30:0];
				CFG_TURN_RATE:   turn_rate_q <= cfg_data[14:0];
				CFG_FWD_RATE:    fwd_rate_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cnt_q)
			4'd1: begin opa = {1'b0, ma_q}; opb = {1'b0, ma_q}; end
			4'd2: begin opa = {1'b0, mb_q}; opb = {1'b0, mb_q}; end
			4'd3: begin opa = 33'(qw_q); opb = 33'(qz_q); end
			4'd4: begin opa = 33'(qx_q); opb = 33'(qy_q); end
			4'd5: begin opa = 33'(qy_q); opb = 33'(qy_q); end
			default: begin opa = 33'(qz_q); opb = 33'(qz_q); end
		endcase
	end

	// CORDIC passes: bearing from the goal offset, then yaw from the quaternion.
	always_comb begin
		cord_start = 1'b0;
		cord_y = 34'(dy_q);
		cord_x = 34'(dx_q);
		sq_start = 1'b0;
		if (state_q == S_MUL && cnt_q == 4'd8) begin
			cord_start = 1'b1;
			sq_start = 1'b1;
		end else if (state_q == S_CORD1 && !cord_busy) begin
			cord_start = 1'b1;
			cord_y = {qa_q[31], qa_q, 1'b0};
			cord_x = 34'sd268435456 - $signed({1'b0, qb_q, 1'b0});
		end
	end

	gtp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .y_in(cord_y), .x_in(cord_x),
		.busy(cord_busy), .z(cord_z)
	);

	gtp_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_q),
		.busy(sq_busy), .root(dist_root)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd8) begin
						state_q <= S_CORD1;
					end
				end
				S_CORD1: begin
					if (!cord_busy) begin
						state_q <= S_CORD2;
					end
				end
				S_CORD2: begin
					if (!cord_busy && !sq_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item datapath: offsets, magnitudes, products and their sums.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dx_q <= 33'(goal_x_q) - 33'(pos_x);
			dy_q <= 33'(goal_y_q) - 33'(pos_y);
			qx_q <= quat_x;
			qy_q <= quat_y;
			qz_q <= quat_z;
			qw_q <= quat_w;
			start_q <= start_req;
			cancel_q <= cancel;
		end
		if (state_q == S_MUL) begin
			if (cnt_q == 4'd0) begin
				ma_q <= dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
				mb_q <= dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
			end
			prod_q <= opa * opb;
			case (cnt_q)
				4'd2: sq_q <= prod_q;
				4'd3: sq_q <= sq_q + prod_q;
				4'd4: qa_q <= prod_q[31:0];
				4'd5: qa_q <= qa_q + prod_q[31:0];
				4'd6: qb_q <= prod_q[31:0];
				4'd7: qb_q <= qb_q + prod_q[31:0];
				default: ;
			endcase
		end
		if (state_q == S_CORD1 && !cord_busy) begin
			bear_q <= cord_z;
		end
	end

	// Heading error: round to the output angle format and saturate.
	always_comb begin
		e30 = (CZW+1)'(bear_q) - (CZW+1)'(cord_z);
		rnd = (CZW+2)'(e30) + (CZW+2)'(64'sd1 <<< (SH - 1));
		shf = rnd >>> SH;
		if (shf > 35'sd32767) begin
			err = 16'sh7FFF;
		end else if (shf < -35'sd32768) begin
			err = -16'sh8000;
		end else begin
			err = shf[15:0];
		end
		err_mag = err[15] ? 17'(-18'(err)) : {1'b0, err};
	end

	// Run decision for this tick.
	always_comb begin
		running = (run_mode_q != MODE_IDLE);
		cancel_eff = cancel_q;
		if (!running && start_q) begin
			running = 1'b1;
			cancel_eff = 1'b0;
		end
		n_mode = run_mode_q;
		n_lin = '0;
		n_ang = '0;
		n_fin = 1'b0;
		n_succ = 1'b0;
		if (running) begin
			if ({1'b0, dist_root} <= {2'b00, arr_tol_q}) begin
				n_fin = 1'b1;
				n_succ = 1'b1;
				n_mode = MODE_IDLE;
			end else if (cancel_eff) begin
				n_fin = 1'b1;
				n_mode = MODE_IDLE;
			end else if (err_mag > {2'b00, head_tol_q}) begin
				n_mode = MODE_TURN;
				n_ang = (err > 16'sd0) ? $signed({1'b0, turn_rate_q})
					: -$signed({1'b0, turn_rate_q});
			end else begin
				n_mode = MODE_DRIVE;
				n_lin = fwd_rate_q;
			end
		end
	end

	assign load_out = (state_q == S_DONE) && (!out_valid || out_ready);

	// Output register and run mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			run_mode_q <= MODE_IDLE;
		end else if (load_out) begin
			out_valid <= 1'b1;
			run_mode_q <= n_mode;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			linear_speed <= n_lin;
			angular_speed <= n_ang;
			drive_mode <= n_mode;
			finished <= n_fin;
			succeeded <= n_succ;
			distance_error <= dist_root;
			heading_error <= err;
		end
	end

	// A success is always a finished run.
	a_succ_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && succeeded |-> finished)
		else $error("success without a finished run");

	// A finished run reports idle with zero speeds.
	a_fin_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> drive_mode == MODE_IDLE && linear_speed == '0
			&& angular_speed == '0)
		else $error("finished run still moving");

	// Turning never drives forward.
	a_turn_nolin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_mode == MODE_TURN |-> linear_speed == '0)
		else $error("forward speed while turning");

	// An input transfer starts the sequencer, which is then busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an input transfer");

	// The run mode never reaches the unused code.
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		run_mode_q != 2'd3)
		else $error("run mode out of range");

endmodule

>>> bench/go_to_point_checker.sv
module go_to_point_checker import gtp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic               start_req,
	input  logic               cancel,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [14:0]        linear_speed,
	input  logic signed [15:0] angular_speed,
	input  logic [1:0]         drive_mode,
	input  logic               finished,
	input  logic               succeeded,
	input  logic [31:0]        distance_error,
	input  logic signed [15:0] heading_error,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 fail_count,
	output int                 awaiting
);

	typedef struct {
		logic [14:0]        lin;
		logic signed [15:0] ang;
		logic [1:0]         mode;
		logic               fin;
		logic               succ;
		logic [31:0]        dist_val;
		logic signed [15:0] herr;
	} command_t;

	// Arctangent of 2^-i, Q2.30 radians, for the sixteen rotation steps.
	localparam longint ATAN_Q30 [16] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767
	};
	localparam longint HALF_PI_Q30 = 1686629713;

	logic signed [31:0] goal_x_q, goal_y_q;
	logic [14:0]        head_tol_q, turn_rate_q, fwd_rate_q;
	logic [30:0]        arrive_tol_q;
	logic [1:0]         run_state;
	command_t           pending_cmds[$];

	function automatic longint unsigned abs64(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Vectoring rotation: angle of (x, y) in Q2.30 radians.
	function automatic longint vector_angle(input longint y, input longint x);
		longint z, nx, ny, xs, ys;
		longint unsigned m;
		int k;
		z = 0;
		k = 0;
		m = abs64(x) | abs64(y);
		if (m == 0)
			return 0;
		while (m < 64'd1 << 40) begin
			m = m << 1;
			k++;
		end
		x = x <<< k;
		y = y <<< k;
		if (x < 0) begin
			if (y >= 0) begin
				nx = y; ny = -x; z = HALF_PI_Q30;
			end else begin
				nx = -y; ny = x; z = -HALF_PI_Q30;
			end
			x = nx;
			y = ny;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += ATAN_Q30[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_Q30[i];
			end
		end
		return z;
	endfunction

	// Exact floor of the Euclidean length, saturated to 32 bits.
	function automatic logic [31:0] range_to_goal(input longint dx, input longint dy);
		logic [65:0] a, b, sq;
		logic [67:0] rem, trial;
		logic [35:0] root;
		if (abs64(dx) > 64'hFFFFFFFF || abs64(dy) > 64'hFFFFFFFF)
			return 32'hFFFFFFFF;
		a = abs64(dx);
		b = abs64(dy);
		sq = a * a + b * b;
		rem = 0;
		root = 0;
		for (int p = 32; p >= 0; p--) begin
			rem = (rem << 2) | sq[2 * p +: 2];
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return (root > 36'hFFFFFFFF) ? 32'hFFFFFFFF : root[31:0];
	endfunction

	// Works out the command for one odometry tick and advances the run state.
	function automatic command_t steer_tick();
		command_t c;
		longint dx, dy, num, den, diff, err;
		logic run, stop;
		dx = longint'(goal_x_q) - longint'(pos_x);
		dy = longint'(goal_y_q) - longint'(pos_y);
		num = 2 * (longint'(quat_w) * quat_z + longint'(quat_x) * quat_y);
		den = (longint'(1) << 28) - 2 * (longint'(quat_y) * quat_y + longint'(quat_z) * quat_z);
		diff = vector_angle(dy, dx) - vector_angle(num, den);
		err = (diff + (longint'(1) << 17)) >>> 18;
		if (err > 32767)
			err = 32767;
		if (err < -32768)
			err = -32768;
		c.lin = 0;
		c.ang = 0;
		c.fin = 0;
		c.succ = 0;
		c.dist_val = range_to_goal(dx, dy);
		c.herr = err[15:0];
		run = (run_state != MODE_IDLE);
		stop = cancel;
		// A start from idle runs in the same tick and drops any cancel with it.
		if (!run && start_req) begin
			run = 1;
			stop = 0;
		end
		if (run) begin
			if (c.dist_val <= {1'b0, arrive_tol_q}) begin
				c.fin = 1; c.succ = 1; run_state = MODE_IDLE;
			end else if (stop) begin
				c.fin = 1; run_state = MODE_IDLE;
			end else if (abs64(err) > head_tol_q) begin
				run_state = MODE_TURN;
				c.ang = (err > 0) ? $signed({1'b0, turn_rate_q}) : -$signed({1'b0, turn_rate_q});
			end else begin
				run_state = MODE_DRIVE;
				c.lin = fwd_rate_q;
			end
		end
		c.mode = run_state;
		return c;
	endfunction

	assign awaiting = pending_cmds.size();

	always @(posedge clk or negedge arst_n) begin
		command_t e;
		if (!arst_n) begin
			goal_x_q <= 0;
			goal_y_q <= 0;
			head_tol_q <= 143;
			arrive_tol_q <= 3277;
			turn_rate_q <= 2662;
			fwd_rate_q <= 2458;
			run_state = MODE_IDLE;
			fail_count <= 0;
			pending_cmds.delete();
		end else begin
			// Register writes.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GOAL_X:      goal_x_q <= cfg_data;
					CFG_GOAL_Y:      goal_y_q <= cfg_data;
					CFG_HEADING_TOL: head_tol_q <= cfg_data[14:0];
					CFG_ARRIVAL_TOL: arrive_tol_q <= cfg_data[30:0];
					CFG_TURN_RATE:   turn_rate_q <= cfg_data[14:0];
					CFG_FWD_RATE:    fwd_rate_q <= cfg_data[14:0];
					default: ;
				endcase
			end
			// Each input transfer yields one command.
			if (in_valid && in_ready)
				pending_cmds.push_back(steer_tick());
			// Compare each output transfer with the oldest prediction.
			if (out_valid && out_ready) begin
				if (pending_cmds.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result transfer at %0t", $realtime);
					fail_count <= fail_count + 1;
				end else begin
					e = pending_cmds.pop_front();
					if (linear_speed !== e.lin || angular_speed !== e.ang ||
							drive_mode !== e.mode || finished !== e.fin ||
							succeeded !== e.succ || distance_error !== e.dist_val ||
							heading_error !== e.herr) begin
						if (fail_count < 10)
							$display({"ERROR: mismatch at %0t: lin %0d/%0d ang %0d/%0d ",
								"mode %0d/%0d fin %0b/%0b succ %0b/%0b dist %0d/%0d ",
								"herr %0d/%0d (expected/actual)"}, $realtime,
								e.lin, linear_speed, e.ang, angular_speed, e.mode,
								drive_mode, e.fin, finished, e.succ, succeeded,
								e.dist_val, distance_error, e.herr, heading_error);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

>>> bench/tb_top.sv
module tb_top;
	import gtp_pkg::*;

	logic               clk, arst_n;
	logic               in_valid, in_ready, out_valid, out_ready;
	logic signed [31:0] pos_x, pos_y;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
	logic               start_req, cancel;
	logic [14:0]        linear_speed;
	logic signed [15:0] angular_speed, heading_error;
	logic [1:0]         drive_mode;
	logic               finished, succeeded;
	logic [31:0]        distance_error;
	logic               cfg_valid, cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	int                 fail_count, awaiting;
	int                 rx_style, burst_left;
	int                 idle_cycles = 0;
	bit                 gaps_on, long_hold_req;
	logic signed [31:0] goal_x_tb, goal_y_tb;

	go_to_point_heading_controller dut (.*);

	go_to_point_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: a stall pattern of its own, plus one long hold-off on request.
	always @(negedge clk) begin
		static int hold = 0;
		if (long_hold_req) begin
			long_hold_req = 0;
			hold = 400;
		end
		if (hold > 0) begin
			hold--;
			out_ready <= 1'b0;
		end else begin
			case (rx_style)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= (($time / 10) % 23 < 15);
			endcase
		end
	end

	// Watchdog on cycles with no transfer of any kind.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_tick(input logic signed [31:0] px, input logic signed [31:0] py,
			input int qx, input int qy, input int qz, input int qw,
			input int st, input int cn);
		pos_x <= px;
		pos_y <= py;
		quat_x <= 16'(qx);
		quat_y <= 16'(qy);
		quat_z <= 16'(qz);
		quat_w <= 16'(qw);
		start_req <= 1'(st);
		cancel <= 1'(cn);
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		burst_left--;
		if (gaps_on && burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
	endtask

	// Stops offering ticks until every predicted command has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (awaiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic int rand_quat();
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	initial begin
		logic signed [31:0] px, py;
		int sh;
		bit pressed;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_GOAL_X;
		cfg_data = 0;
		pos_x = 0;
		pos_y = 0;
		quat_x = 0;
		quat_y = 0;
		quat_z = 0;
		quat_w = 16384;
		start_req = 0;
		cancel = 0;
		rx_style = 0;
		gaps_on = 0;
		burst_left = 4;
		long_hold_req = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed ticks with the reset goal at the origin.
		send_tick(32'h7FFFFFFF, 32'h80000000, 16384, -16384, 16384, -16384, 0, 0);
		send_tick(32'h80000000, 32'h7FFFFFFF, -16384, 16384, -16384, 16384, 0, 1);
		send_tick(0, 0, 0, 0, 0, 16384, 0, 0);
		send_tick(1000, 0, 0, 0, 0, 0, 0, 0);
		send_tick(5000000, 5000000, 0, 0, 16384, 0, 1, 1);
		send_tick(5000000, 5000000, 0, 0, 16384, 0, 1, 0);
		send_tick(5000000, 4000000, 0, 0, 11585, 11585, 0, 0);
		send_tick(-4000000, -4000000, 0, 0, 4000, 15000, 0, 0);
		send_tick(100, -100, 0, 0, 0, 16384, 0, 1);
		send_tick(-3000000, 2000000, 0, 0, 0, 16384, 1, 0);
		send_tick(-3000000, 2000000, 0, 0, -16384, 0, 0, 1);
		send_tick(200000, 0, 0, 0, 0, 16384, 1, 0);
		send_tick(0, 3277, 0, 0, 0, 16384, 0, 1);
		send_tick(0, 0, 0, 0, 0, 16384, 1, 0);
		send_tick(-7000000, -10, 0, 0, 16384, 0, 1, 0);
		send_tick(-7000000, 10, 0, 0, -16384, 0, 0, 0);
		send_tick(32'h80000000, 32'h80000000, 16384, 16384, 16384, 16384, 0, 1);
		send_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 1);
		drain();

		// Configuration phases, each followed by runs toward the goal.
		for (int ph = 0; ph < 7; ph++) begin
			goal_x_tb = $urandom;
			goal_y_tb = $urandom;
			if (ph == 6) begin
				goal_x_tb = 32'h80000000;
				goal_y_tb = 32'h7FFFFFFF;
			end
			write_reg(CFG_GOAL_X, goal_x_tb);
			write_reg(CFG_GOAL_Y, goal_y_tb);
			write_reg(CFG_HEADING_TOL, ph == 0 ? 0 : ph == 1 ? 32767 : $urandom_range(0, 2000));
			write_reg(CFG_ARRIVAL_TOL, ph == 2 ? 0 : ph == 3 ? 32'h7FFFFFFF :
				(ph == 5 ? $urandom & 32'h7FFFFFFF : $urandom_range(0, 1 << 20)));
			write_reg(CFG_TURN_RATE, ph == 4 ? 0 : ph == 5 ? 32767 : $urandom & 32'h7FFF);
			write_reg(CFG_FWD_RATE, ph == 4 ? 0 : ph == 5 ? 32767 : $urandom & 32'h7FFF);
			rx_style = ph % 3;
			gaps_on = (ph % 4 != 3);
			pressed = 0;
			for (int n = 0; n < 200; ) begin
				if (ph == 2 && n >= 100 && !pressed) begin
					pressed = 1;
					long_hold_req = 1;
					gaps_on = 0;
				end
				if (ph == 4 && n >= 100 && !pressed) begin
					pressed = 1;
					drain();
					gaps_on = 1;
				end
				if ($urandom_range(0, 4) == 0) begin
					// Noise: random positions over the full range and random quaternion parts.
					send_tick($urandom, $urandom, rand_quat(), rand_quat(), rand_quat(),
						rand_quat(), $urandom_range(0, 1), $urandom_range(0, 1));
					n++;
				end else begin
					// A run that closes in on the goal, sometimes cancelled.
					sh = $urandom_range(8, 26);
					for (int t = 0; t < 8 && n < 200; t++, n++) begin
						px = goal_x_tb + ($signed($urandom_range(0, 2 << sh)) - (1 << sh));
						py = goal_y_tb + ($signed($urandom_range(0, 2 << sh)) - (1 << sh));
						send_tick(px, py, $urandom_range(0, 1) ? rand_quat() : 0,
							$urandom_range(0, 1) ? rand_quat() : 0, rand_quat(), rand_quat(),
							t == 0 || $urandom_range(0, 15) == 0,
							$urandom_range(0, 19) == 0);
						if (sh > 4)
							sh -= $urandom_range(0, 3);
					end
				end
			end
			drain();
		end

		repeat (100) @(negedge clk);
		if (fail_count == 0 && awaiting == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
